/* rtl/plf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, constants and helpers of the playfair digraph encryptor.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int unsigned SQ_DIM     = 5;
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned IDX_W      = $clog2(SQ_DIM);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = SQ_DIM * CODE_W;

  localparam logic [BYTE_W-1:0] ASCII_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_J = 8'h4A;
  localparam logic [BYTE_W-1:0] ASCII_I = 8'h49;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL  = 3'd6;

  localparam logic [CFG_DATA_W-1:0] ROW0_RST = 25'd4596271;
  localparam logic [CFG_DATA_W-1:0] ROW1_RST = 25'd3212301;
  localparam logic [CFG_DATA_W-1:0] ROW2_RST = 25'd11869381;
  localparam logic [CFG_DATA_W-1:0] ROW3_RST = 25'd21613070;
  localparam logic [CFG_DATA_W-1:0] ROW4_RST = 25'd27025109;
  localparam logic [CODE_W-1:0]     PAD_RST  = 5'd25;
  localparam logic [CODE_W-1:0]     DBL_RST  = 5'd23;

  typedef logic [SQ_DIM-1:0][SQ_DIM-1:0][CODE_W-1:0] plf_sq_t;

  typedef struct packed {
    plf_sq_t           sq;
    logic [CODE_W-1:0] dbl;
  } plf_key_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } plf_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic              not_found;
  } plf_out_t;

  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              last;
  } plf_pair_t;

  function automatic logic [BYTE_W-1:0] map_j(input logic [BYTE_W-1:0] b);
    return (b == ASCII_J) ? ASCII_I : b;
  endfunction

  function automatic logic [BYTE_W-1:0] code2byte(input logic [CODE_W-1:0] code);
    return ASCII_A + BYTE_W'(code);
  endfunction

endpackage

/* rtl/plf_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface plf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/playfair_digraph_encrypt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Playfair encryptor over a configurable 5x5 key square.
//
// in_i takes one ASCII byte per request with a last-of-message flag; J is
// folded to I. The first byte of a pair is held, the second completes it;
// a last byte with nothing held is padded with the pad letter. Each pair
// gives two requests on out_o, the second carrying out_last when the pair
// closed the message, both carrying not_found if a byte was not in the square.
// A completed pair waits in the pair register until the two-entry result
// register has room for its encoding. Throughput: one input byte per cycle
// while in_i is ready, one result per cycle on out_o while the receiver takes
// them. The result register drains while the next pair waits, so in_i stays
// ready for full pairs; a padded pair gives two results for one byte and can
// hold in_i. When out_o stalls, the pair register fills and in_i drops ready.
// Reset restores the default square (PRIME NABCD FGHKL OQSTU VWXYZ), pad Z,
// double X, and clears the held byte and buffers. Users must write the
// configuration port only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt
  import plf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  plf_stream_if.sink            in_i,
  plf_stream_if.source          out_o
);

  plf_sq_t           sq_q;
  logic [CODE_W-1:0] pad_q;
  logic [CODE_W-1:0] dbl_q;

  logic [BYTE_W-1:0] held_q, held_d;
  logic              have_first_q, have_first_d;
  plf_pair_t         pair_q, pair_d;
  logic              pair_vld_q, pair_vld_d;
  plf_out_t [1:0]    res_q;
  plf_out_t [1:0]    enc_res;
  logic [1:0]        cnt_q, cnt_d;

  plf_key_t          key;
  plf_in_t           in_data;
  logic [BYTE_W-1:0] in_b;
  logic              in_fire;
  logic              out_fire;
  logic              buf_load;
  logic              pair_load;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= ROW0_RST;
      sq_q[1] <= ROW1_RST;
      sq_q[2] <= ROW2_RST;
      sq_q[3] <= ROW3_RST;
      sq_q[4] <= ROW4_RST;
      pad_q   <= PAD_RST;
      dbl_q   <= DBL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW0: sq_q[0] <= cfg_data_i;
        CFG_ROW1: sq_q[1] <= cfg_data_i;
        CFG_ROW2: sq_q[2] <= cfg_data_i;
        CFG_ROW3: sq_q[3] <= cfg_data_i;
        CFG_ROW4: sq_q[4] <= cfg_data_i;
        CFG_PAD:  pad_q   <= cfg_data_i[CODE_W-1:0];
        CFG_DBL:  dbl_q   <= cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign key = '{sq: sq_q, dbl: dbl_q};

  // input pairing
  assign in_data  = in_i.data;
  assign in_b     = map_j(in_data.in_byte);
  assign buf_load = pair_vld_q && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_o.ready));
  assign in_i.ready = !pair_vld_q || buf_load;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    held_d       = held_q;
    have_first_d = have_first_q;
    pair_d       = pair_q;
    pair_load    = 1'b0;
    if (in_fire) begin
      if (have_first_q) begin
        pair_d       = '{a: held_q, b: in_b, last: in_data.in_last};
        pair_load    = 1'b1;
        have_first_d = 1'b0;
      end else if (in_data.in_last) begin
        pair_d    = '{a: in_b, b: map_j(code2byte(pad_q)), last: 1'b1};
        pair_load = 1'b1;
      end else begin
        held_d       = in_b;
        have_first_d = 1'b1;
      end
    end
    if (pair_load) begin
      pair_vld_d = 1'b1;
    end else if (buf_load) begin
      pair_vld_d = 1'b0;
    end else begin
      pair_vld_d = pair_vld_q;
    end
  end

  plf_enc u_enc (
    .key_i  (key),
    .pair_i (pair_q),
    .res_o  (enc_res)
  );

  // result register, drained one request per cycle while out_o is ready
  always_comb begin
    if (buf_load) begin
      cnt_d = 2'd2;
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      have_first_q <= 1'b0;
      pair_vld_q   <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      held_q       <= held_d;
      have_first_q <= have_first_d;
      pair_vld_q   <= pair_vld_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    if (buf_load) begin
      res_q <= enc_res;
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = (cnt_q == 2'd2) ? res_q[0] : res_q[1];

  // checks
  plf_out_t out_data;
  assign out_data = out_o.data;

  a_last_on_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_data.out_last |-> cnt_q == 2'd1)
    else $error("out_last on first result of a pair");

  a_nf_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && cnt_q == 2'd2 |=> out_o.valid && out_data.not_found == $past(out_data.not_found))
    else $error("not_found differs within a pair");

  a_pair_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_vld_q && !buf_load |=> pair_vld_q && $stable(pair_q))
    else $error("pending pair lost or changed");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data.in_last |=> !have_first_q && pair_vld_q)
    else $error("last byte left a held letter or no pair");

endmodule

/* rtl/plf_enc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_enc
// Combinational digraph encoder: locates both letters in the key square
// and applies the doubled, same-row, same-column or rectangle rule.
// ----------------------------------------------------------------------------
module plf_enc
  import plf_pkg::*;
(
  input  plf_key_t       key_i,
  input  plf_pair_t      pair_i,
  output plf_out_t [1:0] res_o
);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } loc_t;

  function automatic loc_t locate(input logic [BYTE_W-1:0] b, input plf_sq_t sq);
    loc_t              l;
    logic [BYTE_W-1:0] off;
    l   = '0;
    off = b - ASCII_A;
    if (b >= ASCII_A && b <= ASCII_Z) begin
      // row-major, last match wins
      for (int r = 0; r < SQ_DIM; r++) begin
        for (int c = 0; c < SQ_DIM; c++) begin
          if (sq[r][c] == off[CODE_W-1:0]) begin
            l.found = 1'b1;
            l.row   = IDX_W'(r);
            l.col   = IDX_W'(c);
          end
        end
      end
    end
    return l;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(SQ_DIM - 1)) ? '0 : x + IDX_W'(1);
  endfunction

  loc_t              loc_a;
  loc_t              loc_b;
  logic [BYTE_W-1:0] o1;
  logic [BYTE_W-1:0] o2;
  logic              nf;

  always_comb begin
    loc_a = locate(pair_i.a, key_i.sq);
    loc_b = locate(pair_i.b, key_i.sq);
    nf    = 1'b0;
    if (!loc_a.found || !loc_b.found) begin
      o1 = pair_i.a;
      o2 = pair_i.b;
      nf = 1'b1;
    end else if (pair_i.a == pair_i.b) begin
      o1 = pair_i.a;
      o2 = code2byte(key_i.dbl);
    end else if (loc_a.row == loc_b.row) begin
      o1 = code2byte(key_i.sq[loc_a.row][wrap_inc(loc_a.col)]);
      o2 = code2byte(key_i.sq[loc_b.row][wrap_inc(loc_b.col)]);
    end else if (loc_a.col == loc_b.col) begin
      o1 = code2byte(key_i.sq[wrap_inc(loc_a.row)][loc_a.col]);
      o2 = code2byte(key_i.sq[wrap_inc(loc_b.row)][loc_b.col]);
    end else begin
      o1 = code2byte(key_i.sq[loc_a.row][loc_b.col]);
      o2 = code2byte(key_i.sq[loc_b.row][loc_a.col]);
    end
  end

  assign res_o[0] = '{out_byte: o1, out_last: 1'b0,        not_found: nf};
  assign res_o[1] = '{out_byte: o2, out_last: pair_i.last, not_found: nf};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for playfair_digraph_encrypt. A short directed table
// walks the default key square through every pairing rule, J folding, pad
// and not-found pass-through. Random messages then run under several key
// squares, pad and double letters (all-A, all-unmatched, raw and permuted
// keys). Results are predicted per accepted byte and checked in order, with
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import plf_pkg::*;

  typedef logic [SQ_DIM-1:0][CFG_DATA_W-1:0] key_rows_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
    logic              typed;
    logic [BYTE_W-1:0] e0;
    logic [BYTE_W-1:0] e1;
    logic              nf;
  } dir_row_t;

  localparam int N_DIRECTED = 26;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{"A",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"A",   1'b0, 1'b1, "A",   "X",   1'b0},
    '{"J",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"I",   1'b0, 1'b1, "I",   "X",   1'b0},
    '{"P",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"E",   1'b0, 1'b1, "R",   "P",   1'b0},
    '{"E",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"U",   1'b0, 1'b1, "D",   "Z",   1'b0},
    '{"Z",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"E",   1'b0, 1'b1, "E",   "D",   1'b0},
    '{"P",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"Z",   1'b0, 1'b1, "E",   "V",   1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"A",   1'b0, 1'b1, 8'h00, "A",   1'b1},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"@",   1'b0, 1'b1, 8'hFF, "@",   1'b1},
    '{"Q",   1'b1, 1'b1, "U",   "W",   1'b0},
    '{"C",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"K",   1'b1, 1'b1, "K",   "T",   1'b0},
    '{"a",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"B",   1'b0, 1'b1, "a",   "B",   1'b1},
    '{"[",   1'b1, 1'b1, "[",   "Z",   1'b1},
    '{"H",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"Y",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"Z",   1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
    '{"Z",   1'b1, 1'b1, "Z",   "X",   1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  plf_stream_if #(.T(plf_in_t))  plain_ch ();
  plf_stream_if #(.T(plf_out_t)) cipher_ch ();

  playfair_digraph_encrypt dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (plain_ch),
    .out_o      (cipher_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  key_rows_t         key_row;
  logic [CODE_W-1:0] pad_code;
  logic [CODE_W-1:0] dbl_code;
  logic [BYTE_W-1:0] held_byte;
  bit                holding;

  plf_out_t cipher_q[$];
  plf_out_t want_res;
  int       mismatch_cnt = 0;

  bit src_idle_on   = 1'b1;
  bit sink_idle_on  = 1'b1;
  bit long_hold_req = 1'b0;

  function automatic logic [BYTE_W-1:0] fold_j(input logic [BYTE_W-1:0] b);
    return (b == ASCII_J) ? ASCII_I : b;
  endfunction

  function automatic logic [CODE_W-1:0] cell_code(input int r, input int c);
    return key_row[r][CODE_W*c +: CODE_W];
  endfunction

  // row-major search, last match wins
  function automatic bit find_letter(input logic [BYTE_W-1:0] b, output int r, output int c);
    bit hit;
    hit = 1'b0;
    r = 0;
    c = 0;
    if (b >= ASCII_A && b <= ASCII_Z) begin
      for (int i = 0; i < SQ_DIM; i++) begin
        for (int k = 0; k < SQ_DIM; k++) begin
          if (cell_code(i, k) == CODE_W'(b - ASCII_A)) begin
            r = i;
            c = k;
            hit = 1'b1;
          end
        end
      end
    end
    return hit;
  endfunction

  function automatic void encipher_pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                                        input logic last, output plf_out_t r0,
                                        output plf_out_t r1);
    int ra, ca, rb, cb;
    bit fa, fb;
    logic [BYTE_W-1:0] oa, ob;
    logic nf;
    fa = find_letter(a, ra, ca);
    fb = find_letter(b, rb, cb);
    nf = 1'b0;
    if (!fa || !fb) begin
      oa = a;
      ob = b;
      nf = 1'b1;
    end else if (a == b) begin
      oa = a;
      ob = ASCII_A + BYTE_W'(dbl_code);
    end else if (ra == rb) begin
      oa = ASCII_A + BYTE_W'(cell_code(ra, (ca + 1) % SQ_DIM));
      ob = ASCII_A + BYTE_W'(cell_code(rb, (cb + 1) % SQ_DIM));
    end else if (ca == cb) begin
      oa = ASCII_A + BYTE_W'(cell_code((ra + 1) % SQ_DIM, ca));
      ob = ASCII_A + BYTE_W'(cell_code((rb + 1) % SQ_DIM, cb));
    end else begin
      oa = ASCII_A + BYTE_W'(cell_code(ra, cb));
      ob = ASCII_A + BYTE_W'(cell_code(rb, ca));
    end
    r0.out_byte  = oa;
    r0.out_last  = 1'b0;
    r0.not_found = nf;
    r1.out_byte  = ob;
    r1.out_last  = last;
    r1.not_found = nf;
  endfunction

  function automatic void playfair_step(input logic [BYTE_W-1:0] raw, input logic last,
                                        output int n, output plf_out_t r0, output plf_out_t r1);
    logic [BYTE_W-1:0] b;
    b = fold_j(raw);
    n = 0;
    r0 = '0;
    r1 = '0;
    if (holding) begin
      holding = 1'b0;
      encipher_pair(held_byte, b, last, r0, r1);
      n = 2;
    end else if (last) begin
      encipher_pair(b, fold_j(ASCII_A + BYTE_W'(pad_code)), 1'b1, r0, r1);
      n = 2;
    end else begin
      held_byte = b;
      holding = 1'b1;
    end
  endfunction

  function automatic key_rows_t shuffled_key(input int omit);
    int pool[$];
    key_rows_t rows;
    int k;
    rows = '0;
    for (int l = 0; l < 26; l++) begin
      if (l != omit) pool.push_back(l);
    end
    for (int p = 0; p < SQ_DIM * SQ_DIM; p++) begin
      k = $urandom_range(0, pool.size() - 1);
      rows[p / SQ_DIM][CODE_W*(p % SQ_DIM) +: CODE_W] = CODE_W'(pool[k]);
      pool.delete(k);
    end
    return rows;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROW0: key_row[0] = data;
      CFG_ROW1: key_row[1] = data;
      CFG_ROW2: key_row[2] = data;
      CFG_ROW3: key_row[3] = data;
      CFG_ROW4: key_row[4] = data;
      CFG_PAD:  pad_code = data[CODE_W-1:0];
      CFG_DBL:  dbl_code = data[CODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_key(input key_rows_t rows, input logic [CODE_W-1:0] pad,
                           input logic [CODE_W-1:0] dbl);
    cfg_write(CFG_ROW0, rows[0]);
    cfg_write(CFG_ROW1, rows[1]);
    cfg_write(CFG_ROW2, rows[2]);
    cfg_write(CFG_ROW3, rows[3]);
    cfg_write(CFG_ROW4, rows[4]);
    cfg_write(CFG_PAD, CFG_DATA_W'(pad));
    cfg_write(CFG_DBL, CFG_DATA_W'(dbl));
    cfg_we <= 1'b0;
  endtask

  task automatic send_plain(input logic [BYTE_W-1:0] b, input logic last,
                            input logic typed = 1'b0, input logic [BYTE_W-1:0] t0 = '0,
                            input logic [BYTE_W-1:0] t1 = '0, input logic t_nf = 1'b0);
    int n;
    plf_out_t r0, r1;
    plf_in_t req;
    req.in_byte = b;
    req.in_last = last;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      plain_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    plain_ch.valid <= 1'b1;
    plain_ch.data  <= req;
    do @(posedge clk_i); while (!plain_ch.ready);
    playfair_step(b, last, n, r0, r1);
    if (n == 2) begin
      if (typed) begin
        r0 = '{out_byte: t0, out_last: 1'b0, not_found: t_nf};
        r1 = '{out_byte: t1, out_last: last, not_found: t_nf};
      end
      cipher_q.push_back(r0);
      cipher_q.push_back(r1);
    end
  endtask

  // drop valid, drain, then give the pipeline time to go idle
  task automatic settle();
    plain_ch.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_messages(input int n_items);
    int left, len;
    logic [BYTE_W-1:0] b, prev;
    bit noisy;
    left = n_items;
    prev = ASCII_A;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      noisy = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        if (noisy && $urandom_range(0, 2) == 0) begin
          b = BYTE_W'($urandom_range(0, 255));
        end else if ($urandom_range(0, 5) == 0) begin
          b = prev;
        end else if ($urandom_range(0, 15) == 0) begin
          b = ASCII_J;
        end else begin
          b = ASCII_A + BYTE_W'($urandom_range(0, 25));
        end
        send_plain(b, i == len - 1);
        prev = b;
      end
      left -= len;
    end
  endtask

  task automatic run_phase(input key_rows_t rows, input logic [CODE_W-1:0] pad,
                           input logic [CODE_W-1:0] dbl, input int n_items);
    apply_key(rows, pad, dbl);
    run_messages(n_items);
    settle();
  endtask

  // receiver side
  initial begin
    forever begin
      if (long_hold_req) begin
        cipher_ch.ready <= 1'b0;
        for (int k = 0; k < 120; k++) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        cipher_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        cipher_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cipher_ch.valid && cipher_ch.ready) begin
      if (cipher_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: unexpected request byte %h last %b nf %b", $time,
                   cipher_ch.data.out_byte, cipher_ch.data.out_last, cipher_ch.data.not_found);
        end
      end else begin
        want_res = cipher_q.pop_front();
        if (cipher_ch.data.out_byte !== want_res.out_byte ||
            cipher_ch.data.out_last !== want_res.out_last ||
            cipher_ch.data.not_found !== want_res.not_found) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch exp byte %h last %b nf %b, got byte %h last %b nf %b",
                     $time, want_res.out_byte, want_res.out_last, want_res.not_found,
                     cipher_ch.data.out_byte, cipher_ch.data.out_last,
                     cipher_ch.data.not_found);
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    key_rows_t raw_rows;
    int guard;
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_ROW0;
    cfg_data       <= '0;
    plain_ch.valid <= 1'b0;
    plain_ch.data  <= '0;
    key_row   = {ROW4_RST, ROW3_RST, ROW2_RST, ROW1_RST, ROW0_RST};
    pad_code  = PAD_RST;
    dbl_code  = DBL_RST;
    held_byte = '0;
    holding   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      send_plain(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                 DIRECTED_ROWS[i].e0, DIRECTED_ROWS[i].e1, DIRECTED_ROWS[i].nf);
    end
    settle();

    run_phase(shuffled_key(int'(ASCII_J - ASCII_A)), CODE_W'($urandom_range(0, 25)),
              CODE_W'($urandom_range(0, 25)), 104);
    // every cell A, then no cell a letter
    run_phase('0, '0, '0, 104);
    run_phase('1, '1, '1, 104);

    src_idle_on   = 1'b0;
    long_hold_req = 1'b1;
    run_phase(shuffled_key($urandom_range(0, 25)), CODE_W'(ASCII_J - ASCII_A), 5'd25, 104);
    src_idle_on   = 1'b1;

    for (int r = 0; r < SQ_DIM; r++) raw_rows[r] = CFG_DATA_W'($urandom);
    run_phase(raw_rows, CODE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 31)), 104);
    run_phase(shuffled_key(int'(ASCII_J - ASCII_A)), CODE_W'($urandom_range(0, 25)),
              CODE_W'($urandom_range(0, 25)), 104);

    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_phase({ROW4_RST, ROW3_RST, ROW2_RST, ROW1_RST, ROW0_RST}, PAD_RST, DBL_RST, 104);

    guard = 0;
    while (cipher_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    mismatch_cnt += cipher_q.size();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
